/* rtl/core/lpfd_pkg.sv */
package lpfd_pkg;

    localparam int FSB_DEFAULT = 1024;
    localparam int FSB_MIN     = 16;

    localparam int BYTE_W     = 8;
    localparam int OFF_W      = 10;
    localparam int OFF_RAW_W  = 11;
    localparam int LEN_W      = 16;
    localparam int REM_W      = 10;
    localparam int MOD_STEPS  = OFF_RAW_W - $clog2(FSB_MIN);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_IDX_MAX_LEN = 1'b0;
    localparam logic [OFF_W-1:0] MAX_LEN_RESET = 10'd812;

    localparam logic [BYTE_W-1:0] SYNC0 = 8'h02;
    localparam logic [BYTE_W-1:0] SYNC1 = 8'h80;

    localparam logic [OFF_RAW_W-1:0] OFF_SYNC0  = 11'd0;
    localparam logic [OFF_RAW_W-1:0] OFF_SYNC1  = 11'd1;
    localparam logic [OFF_RAW_W-1:0] OFF_LEN_LO = 11'd2;
    localparam logic [OFF_RAW_W-1:0] OFF_LEN_HI = 11'd3;
    localparam logic [OFF_RAW_W-1:0] OFF_CMD0   = 11'd4;
    localparam logic [OFF_RAW_W-1:0] OFF_CMD1   = 11'd5;
    localparam logic [OFF_RAW_W-1:0] OFF_CMD2   = 11'd6;
    localparam logic [OFF_RAW_W-1:0] OFF_PAY    = 11'd7;
    localparam logic [OFF_RAW_W-1:0] OFF_STATUS_ADJ = 11'd3;

    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_LEN_LO = 4'd1,
        PH_LEN_HI = 4'd2,
        PH_CMD0   = 4'd3,
        PH_CMD1   = 4'd4,
        PH_CMD2   = 4'd5,
        PH_PAY_A  = 4'd6,
        PH_PAY_B  = 4'd7,
        PH_STATUS = 4'd8
    } t_phase;

    typedef struct packed {
        logic                 two;
        logic [BYTE_W-1:0]    data0;
        logic [OFF_RAW_W-1:0] off0;
        logic [BYTE_W-1:0]    data1;
        logic [OFF_RAW_W-1:0] off1;
        logic                 fend;
        logic                 fdrop;
    } t_qent;

endpackage

/* rtl/core/lpfd_front.sv */
module lpfd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [lpfd_pkg::BYTE_W-1:0]  i_data,
    output logic                         o_ready,
    input  logic [lpfd_pkg::OFF_W-1:0]   i_max_len,
    input  logic                         i_full,
    output logic                         o_push,
    output lpfd_pkg::t_qent              o_ent
);
    import lpfd_pkg::*;

    t_phase                r_phase, n_phase;
    logic [BYTE_W-1:0]     r_prev, n_prev;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [OFF_W-1:0]      r_po, n_po;
    logic                  w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_prev  <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_po    <= '0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_po    <= n_po;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_len   = r_len;
        n_rem   = r_rem;
        n_po    = r_po;
        o_push  = 1'b0;
        o_ent   = '0;
        if (w_acc) begin
            case (r_phase)
                PH_LEN_LO: begin
                    n_len       = {8'h00, i_data};
                    n_phase     = PH_LEN_HI;
                    o_push      = 1'b1;
                    o_ent.data0 = i_data;
                    o_ent.off0  = OFF_LEN_LO;
                end
                PH_LEN_HI: begin
                    n_len       = {i_data, r_len[BYTE_W-1:0]};
                    n_phase     = PH_CMD0;
                    o_push      = 1'b1;
                    o_ent.data0 = i_data;
                    o_ent.off0  = OFF_LEN_HI;
                end
                PH_CMD0: begin
                    n_phase     = PH_CMD1;
                    o_push      = 1'b1;
                    o_ent.data0 = i_data;
                    o_ent.off0  = OFF_CMD0;
                end
                PH_CMD1: begin
                    n_phase     = PH_CMD2;
                    o_push      = 1'b1;
                    o_ent.data0 = i_data;
                    o_ent.off0  = OFF_CMD1;
                end
                PH_CMD2: begin
                    o_push      = 1'b1;
                    o_ent.data0 = i_data;
                    o_ent.off0  = OFF_CMD2;
                    if (r_len > {{(LEN_W-OFF_W){1'b0}}, i_max_len}) begin
                        n_phase     = PH_HUNT;
                        n_prev      = '0;
                        o_ent.fdrop = 1'b1;
                    end else begin
                        n_po = '0;
                        if (r_len > 16'd4) begin
                            n_rem   = r_len[REM_W-1:0] - 10'd4;
                            n_phase = PH_PAY_A;
                        end else begin
                            n_rem   = '0;
                            n_phase = PH_STATUS;
                        end
                    end
                end
                PH_PAY_A: begin
                    n_prev  = i_data;
                    n_phase = PH_PAY_B;
                end
                PH_PAY_B: begin
                    n_phase = PH_PAY_A;
                    if (r_prev != '0 || i_data != '0) begin
                        o_push      = 1'b1;
                        o_ent.two   = 1'b1;
                        o_ent.data0 = r_prev;
                        o_ent.off0  = OFF_PAY + {1'b0, r_po};
                        o_ent.data1 = i_data;
                        o_ent.off1  = OFF_PAY + 11'd1 + {1'b0, r_po};
                        n_po        = r_po + 10'd2;
                        if (r_rem <= 10'd2) begin
                            n_rem   = '0;
                            n_phase = PH_STATUS;
                        end else begin
                            n_rem = r_rem - 10'd2;
                        end
                    end
                end
                PH_STATUS: begin
                    if (i_data != '0) begin
                        o_push      = 1'b1;
                        o_ent.data0 = i_data;
                        o_ent.off0  = {1'b0, r_len[OFF_W-1:0]} + OFF_STATUS_ADJ;
                        o_ent.fend  = 1'b1;
                        n_phase     = PH_HUNT;
                        n_prev      = '0;
                    end
                end
                default: begin
                    if (r_prev == SYNC0 && i_data == SYNC1) begin
                        n_phase     = PH_LEN_LO;
                        n_prev      = i_data;
                        o_push      = 1'b1;
                        o_ent.two   = 1'b1;
                        o_ent.data0 = SYNC0;
                        o_ent.off0  = OFF_SYNC0;
                        o_ent.data1 = SYNC1;
                        o_ent.off1  = OFF_SYNC1;
                    end else begin
                        n_phase = PH_HUNT;
                        n_prev  = i_data;
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/core/lpfd_queue.sv */
module lpfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpfd_pkg::t_qent i_ent,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lpfd_pkg::t_qent o_ent
);
    import lpfd_pkg::*;

    t_qent             r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wp, n_wp;
    logic [QP_W-1:0]   r_rp, n_rp;
    logic [QP_W:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QP_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Request pushed into a full queue.");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Request popped from an empty queue.");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QP_W+1)'(Q_DEPTH))
        else $error("Queue fill count exceeds its depth.");
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && i_pop) |=> $stable(r_cnt))
        else $error("Queue fill count moved on a simultaneous push and pop.");
`endif

endmodule

/* rtl/core/lpfd_back.sv */
module lpfd_back #(
    parameter int FRAME_STORE_BYTES = lpfd_pkg::FSB_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  lpfd_pkg::t_qent              i_ent,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lpfd_pkg::BYTE_W-1:0]  o_data,
    output logic [lpfd_pkg::OFF_W-1:0]   o_off,
    output logic                         o_end,
    output logic                         o_drop
);
    import lpfd_pkg::*;

    logic                  r_valid;
    logic                  r_slot, n_slot;
    logic [BYTE_W-1:0]     r_data;
    logic [OFF_W-1:0]      r_off;
    logic                  r_end;
    logic                  r_drop;
    logic                  w_load;
    logic                  w_take;
    logic [BYTE_W-1:0]     w_data;
    logic [OFF_RAW_W-1:0]  w_raw;
    logic [OFF_RAW_W-1:0]  w_mod;

    assign w_load = !r_valid || i_ready;
    assign w_take = w_load && i_q_valid;
    assign o_pop  = w_take && (r_slot || !i_ent.two);

    assign w_data = r_slot ? i_ent.data1 : i_ent.data0;
    assign w_raw  = r_slot ? i_ent.off1 : i_ent.off0;

    // Offsets stay below twice the largest frame, so a short restoring
    // reduction by shifted copies of the store size gives the remainder.
    always_comb begin
        w_mod = w_raw;
        for (int j = MOD_STEPS - 1; j >= 0; j--) begin
            if (32'(w_mod) >= (FRAME_STORE_BYTES << j)) begin
                w_mod = w_mod - OFF_RAW_W'(FRAME_STORE_BYTES << j);
            end
        end
    end

    always_comb begin
        n_slot = r_slot;
        if (w_take) begin
            n_slot = (r_slot || !i_ent.two) ? 1'b0 : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (w_load) begin
                r_valid <= i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= w_data;
            r_off  <= w_mod[OFF_W-1:0];
            r_end  <= !r_slot && i_ent.fend;
            r_drop <= !r_slot && i_ent.fdrop;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_off   = r_off;
    assign o_end   = r_end;
    assign o_drop  = r_drop;

endmodule

/* rtl/core/length_prefixed_frame_deframer.sv */
// Byte-stream deframer for length-prefixed serial telegrams. Each received byte
// is taken on s_axis; the block hunts for the sync pair 0x02 0x80, then passes
// on the header bytes, the nonzero payload byte pairs and the closing status
// byte as frame requests on m_axis, each with its offset in the frame (wrapped
// to FRAME_STORE_BYTES). tlast marks the status byte; tuser marks the last
// command byte of a frame whose length field exceeds max_frame_length, after
// which the hunt restarts. One byte is accepted every cycle while the queue
// has room, and one request is delivered every cycle while m_axis_tready is
// high. A byte that completes the sync pair or a payload pair yields two
// requests, and the four-entry queue between the parser and the output stage
// absorbs these bursts; s_axis_tready drops only while that queue is full.
// A request passes through the queue and the output register to m_axis.
// max_frame_length, at byte address 0 of the register port, resets to 812.
module length_prefixed_frame_deframer #(
    parameter int FRAME_STORE_BYTES = lpfd_pkg::FSB_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // [7:0] frame_byte,
                                                             // [17:8] frame_offset
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser,  // [0] frame_dropped
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpfd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [lpfd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [lpfd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lpfd_pkg::*;

    logic [OFF_W-1:0]   r_max_len;
    logic               w_sel_max;
    logic               w_full;
    logic               w_push;
    t_qent              w_push_ent;
    logic               w_q_valid;
    logic               w_pop;
    t_qent              w_head;
    logic [BYTE_W-1:0]  w_out_data;
    logic [OFF_W-1:0]   w_out_off;

    assign pready    = 1'b1;
    assign w_sel_max = (paddr[CFG_ADDR_W-1:2] == REG_IDX_MAX_LEN);
    assign prdata    = w_sel_max ? {{(CFG_DATA_W-OFF_W){1'b0}}, r_max_len} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_max) begin
            r_max_len <= pwdata[OFF_W-1:0];
        end
    end

    lpfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .o_ready   (s_axis_tready),
        .i_max_len (r_max_len),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_ent     (w_push_ent)
    );

    lpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_ent   (w_head)
    );

    lpfd_back #(
        .FRAME_STORE_BYTES (FRAME_STORE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_ent     (w_head),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (w_out_data),
        .o_off     (w_out_off),
        .o_end     (m_axis_tlast),
        .o_drop    (m_axis_tuser)
    );

    assign m_axis_tdata = {6'b0, w_out_off, w_out_data};

endmodule
